// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define MCDT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mcdt_pkg.sv
// ----------------------------------------------------------------------------
// mcdt_pkg
// types, codes and helpers shared by the deadline timer core
// ----------------------------------------------------------------------------
package mcdt_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int DATA_W       = 32;
	localparam int REQ_W        = 3;
	localparam int CH_W         = 3;
	localparam int TCMD_W       = 2;

	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SET_PERIOD = 3'd0;
	localparam logic [REQ_W-1:0] REQ_START_ONCE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START_REP  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DISABLE    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ELAPSED    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

	// hardware timer orders
	localparam logic [TCMD_W-1:0] TCMD_NONE    = 2'd0;
	localparam logic [TCMD_W-1:0] TCMD_STOP    = 2'd1;
	localparam logic [TCMD_W-1:0] TCMD_RESTART = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REM,
		ST_UPD,
		ST_MIN,
		ST_CALC,
		ST_START,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic              period_we;
		logic [DATA_W-1:0] period;
		logic              dl_we;
		logic [DATA_W-1:0] dl;
		logic              rep_we;
		logic              rep;
	} store_wr_t;

	// 2*(dl - now) - 1 taken as {dl - now - 1, 1}
	function automatic logic [DATA_W-1:0] reload_for(input logic [DATA_W-1:0] dl,
			input logic [DATA_W-1:0] now);
		logic [DATA_W-1:0] x;
		x = dl + ~now;
		return {x[DATA_W-2:0], 1'b1};
	endfunction

endpackage

// File: hdl/mcdt_rem_unit.sv
// ----------------------------------------------------------------------------
// mcdt_rem_unit
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mcdt_rem_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mcdt_pkg::DATA_W-1:0] dividend,
	input  logic [mcdt_pkg::DATA_W-1:0] divisor,
	output logic                        done,
	output logic [mcdt_pkg::DATA_W-1:0] rem
);
	import mcdt_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W:0]   r_sh;
	logic [DATA_W:0]   r_sub;
	logic              r_ge;

	assign r_sh  = {rem_q, dvd_q[DATA_W-1]};
	assign r_sub = r_sh - {1'b0, dvs_q};
	assign r_ge  = (r_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= r_ge ? r_sub[DATA_W-1:0] : r_sh[DATA_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hdl/mcdt_chan_store.sv
// ----------------------------------------------------------------------------
// mcdt_chan_store
// per-channel period, deadline and repeat flag with one shared address
// ----------------------------------------------------------------------------
module mcdt_chan_store #(
	parameter int CHANNELS = mcdt_pkg::CHANNELS_DEF,
	parameter int IW       = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [IW-1:0]               addr,
	input  mcdt_pkg::store_wr_t         wr,
	output logic [mcdt_pkg::DATA_W-1:0] rd_period,
	output logic [mcdt_pkg::DATA_W-1:0] rd_deadline,
	output logic                        rd_repeat
);
	import mcdt_pkg::*;

	logic [DATA_W-1:0] period_q   [CHANNELS];
	logic [DATA_W-1:0] deadline_q [CHANNELS];
	logic              repeat_q   [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				period_q[i]   <= '0;
				deadline_q[i] <= ALL_ONES;
				repeat_q[i]   <= 1'b0;
			end
		end else begin
			if (wr.period_we) begin
				period_q[addr] <= wr.period;
			end
			if (wr.dl_we) begin
				deadline_q[addr] <= wr.dl;
			end
			if (wr.rep_we) begin
				repeat_q[addr] <= wr.rep;
			end
		end
	end

	assign rd_period   = period_q[addr];
	assign rd_deadline = deadline_q[addr];
	assign rd_repeat   = repeat_q[addr];

endmodule

// File: hdl/multi_channel_deadline_timer_core.sv
// elapsed: scans each channel in turn; a due repeating channel with a nonzero
//   period also runs the remainder unit; ST_CALC and ST_FINAL close the item
// start once / repeating: earliest-deadline scan, ST_CALC, ST_START, ST_FINAL
// set period, disable, query, ignored requests: ST_CALC, then ST_FINAL
// one item at a time; stalled results delay it. reset: all channels stopped,
//   periods and repeat flags zero, no result pending
// ----------------------------------------------------------------------------
// multi_channel_deadline_timer_core
// virtual timers multiplexed on one hardware timer, channel scan sequencer
// ----------------------------------------------------------------------------
module multi_channel_deadline_timer_core #(
	parameter int CHANNELS = mcdt_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mcdt_pkg::REQ_W-1:0]  req_type,
	input  logic [mcdt_pkg::CH_W-1:0]   channel,
	input  logic [mcdt_pkg::DATA_W-1:0] period_ms,
	input  logic [mcdt_pkg::DATA_W-1:0] now_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        fired,
	output logic [mcdt_pkg::CH_W-1:0]   fired_channel,
	output logic [mcdt_pkg::TCMD_W-1:0] timer_cmd,
	output logic [mcdt_pkg::DATA_W-1:0] timer_reload,
	output logic                        running,
	output logic                        last
);
	import mcdt_pkg::*;

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

	state_t state_q, state_d;

	logic [REQ_W-1:0]  req_q;
	logic              ok_q;
	logic [IW-1:0]     ch_q;
	logic [DATA_W-1:0] now_q;
	logic [DATA_W-1:0] period_q;
	logic [IW-1:0]     idx_q, idx_d;
	logic [DATA_W-1:0] min_q, min_d;
	logic              any_q, any_d;
	logic [DATA_W-1:0] add_q, add_d;
	logic [DATA_W-1:0] nd_q, nd_d;
	logic [TCMD_W-1:0] fin_cmd_q, fin_cmd_d;
	logic [DATA_W-1:0] fin_reload_q, fin_reload_d;
	logic              fin_run_q, fin_run_d;

	logic              out_valid_q;
	logic              out_fired_q, out_fired_d;
	logic [CH_W-1:0]   out_ch_q, out_ch_d;
	logic [TCMD_W-1:0] out_cmd_q, out_cmd_d;
	logic [DATA_W-1:0] out_reload_q, out_reload_d;
	logic              out_run_q, out_run_d;
	logic              out_last_q, out_last_d;
	logic              out_load;
	logic              out_free;

	logic              in_xfer;
	logic              in_ok;
	logic [IW-1:0]     in_idx;

	store_wr_t         wr;
	logic [DATA_W-1:0] rd_period;
	logic [DATA_W-1:0] rd_dl;
	logic              rd_rep;

	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_rem;

	logic              due;
	logic [DATA_W-1:0] new_dl;
	logic [DATA_W:0]   upd_sum;
	logic [DATA_W:0]   start_sum;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign in_ok    = ({{(DATA_W-CH_W){1'b0}}, channel} < DATA_W'(CHANNELS));
	assign in_idx   = IW'({{(DATA_W-CH_W){1'b0}}, channel});
	assign out_free = !out_valid_q || !out_stall;

	assign due       = (rd_dl != ALL_ONES) && (rd_dl <= now_q);
	assign upd_sum   = {1'b0, now_q} + {1'b0, add_q};
	assign start_sum = {1'b0, now_q} + {1'b0, rd_period};

	mcdt_chan_store #(
		.CHANNELS (CHANNELS),
		.IW       (IW)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.addr        (idx_q),
		.wr          (wr),
		.rd_period   (rd_period),
		.rd_deadline (rd_dl),
		.rd_repeat   (rd_rep)
	);

	mcdt_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (now_q - rd_dl),
		.divisor  (rd_period),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q    <= req_type;
			ok_q     <= in_ok;
			ch_q     <= in_idx;
			now_q    <= now_ms;
			period_q <= period_ms;
		end
		idx_q        <= idx_d;
		min_q        <= min_d;
		any_q        <= any_d;
		add_q        <= add_d;
		nd_q         <= nd_d;
		fin_cmd_q    <= fin_cmd_d;
		fin_reload_q <= fin_reload_d;
		fin_run_q    <= fin_run_d;
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		min_d        = min_q;
		any_d        = any_q;
		add_d        = add_q;
		nd_d         = nd_q;
		fin_cmd_d    = fin_cmd_q;
		fin_reload_d = fin_reload_q;
		fin_run_d    = fin_run_q;
		wr           = '0;
		wr.period    = period_q;
		div_start    = 1'b0;
		new_dl       = ALL_ONES;
		out_load     = 1'b0;
		out_fired_d  = 1'b0;
		out_ch_d     = '0;
		out_cmd_d    = TCMD_NONE;
		out_reload_d = '0;
		out_run_d    = 1'b0;
		out_last_d   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					min_d        = ALL_ONES;
					any_d        = 1'b0;
					fin_cmd_d    = TCMD_NONE;
					fin_reload_d = '0;
					fin_run_d    = 1'b0;
					if (req_type == REQ_ELAPSED) begin
						idx_d   = '0;
						state_d = ST_SCAN;
					end else if (in_ok && (req_type == REQ_START_ONCE ||
							req_type == REQ_START_REP)) begin
						idx_d   = '0;
						state_d = ST_MIN;
					end else begin
						idx_d   = in_ok ? in_idx : '0;
						state_d = ST_CALC;
					end
				end
			end

			ST_SCAN: begin
				if (!due) begin
					if (rd_dl < min_q) begin
						min_d = rd_dl;
					end
					if (idx_q == LAST_IDX) begin
						state_d = ST_CALC;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end else if (out_free) begin
					out_load    = 1'b1;
					out_fired_d = 1'b1;
					out_ch_d    = CH_W'({{(DATA_W-IW){1'b0}}, idx_q});
					any_d       = 1'b1;
					if (rd_rep && rd_period != '0) begin
						div_start = 1'b1;
						state_d   = ST_REM;
					end else begin
						// zero period catches up to now, one-shot stops
						new_dl   = rd_rep ? now_q : ALL_ONES;
						wr.dl_we = 1'b1;
						wr.dl    = new_dl;
						if (new_dl < min_q) begin
							min_d = new_dl;
						end
						if (idx_q == LAST_IDX) begin
							state_d = ST_CALC;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
				end
			end

			ST_REM: begin
				if (div_done) begin
					// step from now to the next period boundary, a full period if dl == now
					if (div_rem == '0) begin
						add_d = (rd_dl == now_q) ? rd_period : '0;
					end else begin
						add_d = rd_period - div_rem;
					end
					state_d = ST_UPD;
				end
			end

			ST_UPD: begin
				new_dl   = upd_sum[DATA_W] ? ALL_ONES : upd_sum[DATA_W-1:0];
				wr.dl_we = 1'b1;
				wr.dl    = new_dl;
				if (new_dl < min_q) begin
					min_d = new_dl;
				end
				if (idx_q == LAST_IDX) begin
					state_d = ST_CALC;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_SCAN;
				end
			end

			ST_MIN: begin
				if (rd_dl < min_q) begin
					min_d = rd_dl;
				end
				if (idx_q == LAST_IDX) begin
					idx_d   = ch_q;
					state_d = ST_CALC;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end

			ST_CALC: begin
				state_d = ST_FINAL;
				priority if (req_q == REQ_ELAPSED) begin
					if (!any_q) begin
						fin_cmd_d = TCMD_NONE;
					end else if (min_q == ALL_ONES) begin
						fin_cmd_d = TCMD_STOP;
					end else begin
						fin_cmd_d    = TCMD_RESTART;
						fin_reload_d = reload_for(min_q, now_q);
					end
				end else if (!ok_q) begin
					fin_cmd_d = TCMD_NONE;
				end else if (req_q == REQ_SET_PERIOD) begin
					wr.period_we = 1'b1;
				end else if (req_q == REQ_START_ONCE || req_q == REQ_START_REP) begin
					nd_d    = start_sum[DATA_W] ? ALL_ONES : start_sum[DATA_W-1:0];
					state_d = ST_START;
				end else if (req_q == REQ_DISABLE) begin
					wr.dl_we  = 1'b1;
					wr.dl     = ALL_ONES;
					wr.rep_we = 1'b1;
					wr.rep    = 1'b0;
				end else if (req_q == REQ_QUERY) begin
					fin_run_d = (rd_dl != ALL_ONES);
				end else begin
					// undefined request codes
					fin_cmd_d = TCMD_NONE;
				end
			end

			ST_START: begin
				wr.dl_we  = 1'b1;
				wr.dl     = nd_q;
				wr.rep_we = 1'b1;
				wr.rep    = (req_q == REQ_START_REP);
				if (nd_q < min_q) begin
					fin_cmd_d    = TCMD_RESTART;
					fin_reload_d = reload_for(nd_q, now_q);
				end
				state_d = ST_FINAL;
			end

			ST_FINAL: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_cmd_d    = fin_cmd_q;
					out_reload_d = fin_reload_q;
					out_run_d    = fin_run_q;
					out_last_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

	// output register, refilled as soon as the pending transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fired_q  <= out_fired_d;
			out_ch_q     <= out_ch_d;
			out_cmd_q    <= out_cmd_d;
			out_reload_q <= out_reload_d;
			out_run_q    <= out_run_d;
			out_last_q   <= out_last_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign fired         = out_fired_q;
	assign fired_channel = out_ch_q;
	assign timer_cmd     = out_cmd_q;
	assign timer_reload  = out_reload_q;
	assign running       = out_run_q;
	assign last          = out_last_q;

endmodule

// File: hdl/mcdt_checker.sv
// ----------------------------------------------------------------------------
// mcdt_checker
// port-level checks of the deadline timer core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcdt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        fired,
	input logic [mcdt_pkg::CH_W-1:0]   fired_channel,
	input logic [mcdt_pkg::TCMD_W-1:0] timer_cmd,
	input logic [mcdt_pkg::DATA_W-1:0] timer_reload,
	input logic                        running,
	input logic                        last
);
	import mcdt_pkg::*;

	// stalled result holds
	`MCDT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(timer_reload) && $stable(last) && $stable(fired_channel),
		"stalled result changed")

	// a channel report never closes an item nor carries a timer order
	`MCDT_ASSERT(a_fired_not_final,
		out_valid && fired |-> !last && timer_cmd == TCMD_NONE && !running,
		"fired result carries final fields")

	// running only comes with a final result
	`MCDT_ASSERT(a_running_final,
		out_valid && running |-> last && !fired && timer_cmd == TCMD_NONE,
		"running outside a query result")

	// 2*dT - 1 is always odd
	`MCDT_ASSERT(a_reload_odd,
		out_valid && timer_cmd == TCMD_RESTART |-> timer_reload[0] && last,
		"restart reload is even")

	// an accepted transfer leaves the core busy in the following cycle
	`MCDT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"core not busy after accept")

endmodule

bind multi_channel_deadline_timer_core mcdt_checker u_mcdt_checker (.*);

// File: bench/tb_multi_channel_deadline_timer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_channel_deadline_timer_core
// self-checking bench: a short directed command list, then random command
// traffic in three idle/stall phases, checked result by result against an
// in-bench prediction of the channel periods, deadlines and repeat flags
// ----------------------------------------------------------------------------
module tb_multi_channel_deadline_timer_core;
	import mcdt_pkg::*;

	localparam int CHANNELS    = CHANNELS_DEF;
	localparam int RANDOM_CMDS = 350;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 300;

	// request codes the block ignores
	localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [CH_W-1:0]   ch;
		logic [DATA_W-1:0] period;
		logic [DATA_W-1:0] now;
		logic [1:0]        phase;
		logic              drain;
	} timer_cmd_t;

	typedef struct packed {
		logic              fired;
		logic [CH_W-1:0]   fch;
		logic [TCMD_W-1:0] cmd;
		logic [DATA_W-1:0] reload;
		logic              running;
		logic              last;
	} timer_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic [CH_W-1:0] channel = '0;
	logic [DATA_W-1:0] period_ms = '0;
	logic [DATA_W-1:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic fired;
	logic [CH_W-1:0] fired_channel;
	logic [TCMD_W-1:0] timer_cmd;
	logic [DATA_W-1:0] timer_reload;
	logic running;
	logic last;

	multi_channel_deadline_timer_core #(.CHANNELS(CHANNELS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.channel      (channel),
		.period_ms    (period_ms),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fired        (fired),
		.fired_channel(fired_channel),
		.timer_cmd    (timer_cmd),
		.timer_reload (timer_reload),
		.running      (running),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	timer_cmd_t     cmd_feed[$];
	timer_event_t   events_awaited[$];
	logic [DATA_W-1:0] period_tbl[CHANNELS];
	logic [DATA_W-1:0] deadline_tbl[CHANNELS];
	logic              repeat_tbl[CHANNELS];

	int send_idle_pct[3]  = '{16, 60, 0};
	int recv_stall_pct[3] = '{60, 16, 0};
	int cur_phase = 0;
	logic in_took = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;
	int n_cmds = 0, n_elapsed = 0, n_events = 0, n_fired = 0, n_restart = 0, n_stop = 0;

	function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? ALL_ONES : s[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] half_ms_reload(input logic [DATA_W-1:0] dl,
			input logic [DATA_W-1:0] now);
		logic [DATA_W-1:0] dt;
		dt = dl - now;
		return dt * 32'd2 - 32'd1;
	endfunction

	function automatic logic [DATA_W-1:0] earliest_deadline();
		logic [DATA_W-1:0] t;
		t = ALL_ONES;
		for (int i = 0; i < CHANNELS; i++)
			if (deadline_tbl[i] < t)
				t = deadline_tbl[i];
		return t;
	endfunction

	// updates the channel state for one command and queues the results it causes
	function automatic void derive_timer_events(input timer_cmd_t c);
		timer_event_t ev;
		logic any_due;
		logic [DATA_W-1:0] d, p, t, near, nd32;
		logic [63:0] diff, k, nd;
		ev = '0;
		ev.last = 1'b1;
		if (c.req == REQ_ELAPSED) begin
			n_elapsed++;
			any_due = 1'b0;
			for (int i = 0; i < CHANNELS; i++)
				if (deadline_tbl[i] != ALL_ONES && deadline_tbl[i] <= c.now)
					any_due = 1'b1;
			if (any_due) begin
				for (int i = 0; i < CHANNELS; i++) begin
					d = deadline_tbl[i];
					if (d != ALL_ONES && d <= c.now) begin
						events_awaited.push_back('{fired: 1'b1, fch: CH_W'(i), cmd: TCMD_NONE,
							reload: '0, running: 1'b0, last: 1'b0});
						n_fired++;
						if (repeat_tbl[i]) begin
							p = period_tbl[i];
							if (p == '0) begin
								deadline_tbl[i] = c.now;
							end else begin
								// catch up by whole periods, at least one
								diff = {32'd0, c.now - d};
								k = (diff + {32'd0, p} - 64'd1) / {32'd0, p};
								if (k == 64'd0)
									k = 64'd1;
								nd = {32'd0, d} + k * {32'd0, p};
								deadline_tbl[i] = (nd > {32'd0, ALL_ONES}) ? ALL_ONES : nd[31:0];
							end
						end else begin
							deadline_tbl[i] = ALL_ONES;
						end
					end
				end
				t = earliest_deadline();
				if (t == ALL_ONES) begin
					ev.cmd = TCMD_STOP;
					n_stop++;
				end else begin
					ev.cmd = TCMD_RESTART;
					ev.reload = half_ms_reload(t, c.now);
					n_restart++;
				end
			end
		end else if (int'(c.ch) < CHANNELS && c.req <= REQ_QUERY) begin
			case (c.req)
				REQ_SET_PERIOD: begin
					period_tbl[c.ch] = c.period;
				end
				REQ_START_ONCE, REQ_START_REP: begin
					near = earliest_deadline();
					nd32 = sat_sum(c.now, period_tbl[c.ch]);
					repeat_tbl[c.ch] = (c.req == REQ_START_REP);
					deadline_tbl[c.ch] = nd32;
					if (nd32 < near) begin
						ev.cmd = TCMD_RESTART;
						ev.reload = half_ms_reload(nd32, c.now);
						n_restart++;
					end
				end
				REQ_DISABLE: begin
					deadline_tbl[c.ch] = ALL_ONES;
					repeat_tbl[c.ch] = 1'b0;
				end
				default: begin
					ev.running = (deadline_tbl[c.ch] != ALL_ONES);
				end
			endcase
		end
		events_awaited.push_back(ev);
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void queue_cmd(input logic [REQ_W-1:0] req, input int ch,
			input logic [DATA_W-1:0] period, input logic [DATA_W-1:0] now,
			input int phase, input logic drain);
		cmd_feed.push_back('{req: req, ch: CH_W'(ch), period: period, now: now,
			phase: 2'(phase), drain: drain});
	endfunction

	// driver: command side and result-side stall, both changed on the falling edge
	always @(negedge clk) begin
		timer_cmd_t nxt;
		logic go;
		if (arst_n) begin
			if (!in_valid || in_took) begin
				go = 1'b0;
				if (cmd_feed.size() > 0) begin
					nxt = cmd_feed[0];
					if (!(nxt.drain && events_awaited.size() > 0) &&
							$urandom_range(0, 99) >= send_idle_pct[nxt.phase]) begin
						go = 1'b1;
						void'(cmd_feed.pop_front());
						cur_phase = nxt.phase;
						req_type <= nxt.req;
						channel <= nxt.ch;
						period_ms <= nxt.period;
						now_ms <= nxt.now;
					end
				end
				in_valid <= go;
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct[cur_phase]);
		end
	end

	// monitor: predicts on each command transfer, checks each result transfer
	always @(posedge clk) begin
		timer_cmd_t c;
		timer_event_t want;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				c = '{req: req_type, ch: channel, period: period_ms, now: now_ms,
					phase: 2'd0, drain: 1'b0};
				derive_timer_events(c);
				n_cmds++;
			end
			if (out_valid && !out_stall) begin
				n_events++;
				if (events_awaited.size() == 0) begin
					$display("%0t: unexpected result: fired %0b cmd %0d last %0b",
						$time, fired, timer_cmd, last);
					errors++;
				end else begin
					want = events_awaited.pop_front();
					check_field("fired", DATA_W'(want.fired), DATA_W'(fired));
					check_field("fired_channel", DATA_W'(want.fch), DATA_W'(fired_channel));
					check_field("timer_cmd", DATA_W'(want.cmd), DATA_W'(timer_cmd));
					check_field("timer_reload", want.reload, timer_reload);
					check_field("running", DATA_W'(want.running), DATA_W'(running));
					check_field("last", DATA_W'(want.last), DATA_W'(last));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] wall;
		logic [DATA_W-1:0] per;
		logic [REQ_W-1:0] req;
		int roll, phase;
		for (int i = 0; i < CHANNELS; i++) begin
			period_tbl[i] = '0;
			deadline_tbl[i] = ALL_ONES;
			repeat_tbl[i] = 1'b0;
		end

		// directed: stopped channels, restart ordering, zero period, saturation,
		// catch-up, ignored codes, full stop
		queue_cmd(REQ_QUERY, 0, '0, '0, 0, 1'b0);
		queue_cmd(REQ_ELAPSED, 0, '0, ALL_ONES, 0, 1'b0);
		queue_cmd(REQ_SET_PERIOD, 0, 32'd10, '0, 0, 1'b0);
		queue_cmd(REQ_START_ONCE, 0, '0, 32'd100, 0, 1'b0);
		queue_cmd(REQ_SET_PERIOD, 7, '0, '0, 0, 1'b0);
		queue_cmd(REQ_START_REP, 7, ALL_ONES, 32'd200, 0, 1'b0);
		queue_cmd(REQ_QUERY, 0, '0, 32'd101, 0, 1'b0);
		queue_cmd(REQ_ELAPSED, 0, '0, 32'd105, 0, 1'b0);
		queue_cmd(REQ_ELAPSED, 0, '0, 32'd250, 0, 1'b0);
		queue_cmd(REQ_SET_PERIOD, 3, ALL_ONES, '0, 0, 1'b0);
		queue_cmd(REQ_START_REP, 3, '0, 32'd5, 0, 1'b0);
		queue_cmd(REQ_QUERY, 3, '0, 32'd5, 0, 1'b0);
		queue_cmd(REQ_SET_PERIOD, 1, 32'd7, '0, 0, 1'b0);
		queue_cmd(REQ_START_REP, 1, '0, 32'd1000, 0, 1'b0);
		queue_cmd(REQ_DISABLE, 7, '0, 32'd1001, 0, 1'b0);
		queue_cmd(REQ_ELAPSED, 0, '0, 32'd2000, 0, 1'b0);
		queue_cmd(REQ_SET_PERIOD, 2, 32'h8000_0000, '0, 0, 1'b0);
		queue_cmd(REQ_START_REP, 2, '0, 32'h7FFF_FFF0, 0, 1'b0);
		queue_cmd(REQ_ELAPSED, 0, '0, 32'hFFFF_FFF5, 0, 1'b0);
		queue_cmd(REQ_RSVD_LO, 5, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_cmd(REQ_RSVD_HI, 7, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_cmd(REQ_START_ONCE, 4, ALL_ONES, '0, 0, 1'b0);
		queue_cmd(REQ_DISABLE, 1, '0, '0, 0, 1'b0);
		queue_cmd(REQ_ELAPSED, 0, '0, '0, 0, 1'b0);
		queue_cmd(REQ_START_ONCE, 0, '0, ALL_ONES - 32'd3, 0, 1'b1);

		// random: slowly advancing time, mostly short periods, rare jumps
		wall = 32'd5000;
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			phase = i * 3 / RANDOM_CMDS;
			roll = $urandom_range(0, 99);
			if (roll < 18)
				req = REQ_SET_PERIOD;
			else if (roll < 32)
				req = REQ_START_ONCE;
			else if (roll < 46)
				req = REQ_START_REP;
			else if (roll < 54)
				req = REQ_DISABLE;
			else if (roll < 84)
				req = REQ_ELAPSED;
			else if (roll < 94)
				req = REQ_QUERY;
			else
				req = $urandom_range(0, 1) ? REQ_RSVD_HI : REQ_RSVD_LO;
			per = $urandom;
			if (req == REQ_SET_PERIOD) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					per = $urandom_range(1, 60);
				else if (roll < 80)
					per = '0;
				else if (roll < 90)
					per = ALL_ONES - $urandom_range(0, 100);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				wall = $urandom;
			else if (roll < 5)
				wall = ALL_ONES - $urandom_range(0, 40);
			else
				wall = wall + $urandom_range(0, 30);
			queue_cmd(req, $urandom_range(0, 7), per, wall, phase,
				(i > 0 && (i * 3 / RANDOM_CMDS) != ((i - 1) * 3 / RANDOM_CMDS)) ||
				$urandom_range(0, 39) == 0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_feed.size() > 0 || in_valid || events_awaited.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (events_awaited.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, events_awaited.size());
			errors++;
		end
		$display("ran %0d commands (%0d elapsed events) through three idle/stall phases",
			n_cmds, n_elapsed);
		$display("checked %0d results: %0d channel expirations, %0d restarts, %0d stops",
			n_events, n_fired, n_restart, n_stop);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/mcdt_pkg.sv
hdl/mcdt_rem_unit.sv
hdl/mcdt_chan_store.sv
hdl/multi_channel_deadline_timer_core.sv
hdl/mcdt_checker.sv
bench/tb_multi_channel_deadline_timer_core.sv
